/* rtl/voxel_ray_step_unit_defines.svh */
// assertion macros for the voxel ray step unit
// no dependencies; taken in by the top level only
`ifndef VOXEL_RAY_STEP_UNIT_DEFINES_SVH
`define VOXEL_RAY_STEP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VRS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrs assertion failed");
`define VRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrs assertion failed");
`else
`define VRS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define VRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/vrs_pkg.sv */
// shared widths, codes and defaults of the voxel ray step unit
// no dependencies
package vrs_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CELL_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int QUO_W         = 64;
   localparam int ROOT_W        = 32;
   localparam int CELL_OUT_W    = 16;
   localparam int CSR_ADDR_W    = 5;

   localparam logic [2:0] REG_DIR_X = 3'd0;
   localparam logic [2:0] REG_DIR_Y = 3'd1;
   localparam logic [2:0] REG_DIR_Z = 3'd2;
   localparam logic [2:0] REG_ORG_X = 3'd3;
   localparam logic [2:0] REG_ORG_Y = 3'd4;
   localparam logic [2:0] REG_ORG_Z = 3'd5;

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_MOVED   = 2'd0,
      ST_HIT     = 2'd1,
      ST_NO_EXIT = 2'd2,
      ST_STARTED = 2'd3
   } status_type;
endpackage

/* rtl/vrs_mul.sv */
// registered 32x32 unsigned multiplier shared by the step sequencer
// uses vrs_pkg
module vrs_mul import vrs_pkg::*; (
   input  logic              clock,
   input  logic [DATA_W-1:0] op_a,
   input  logic [DATA_W-1:0] op_b,
   output logic [PROD_W-1:0] prod
);
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;
endmodule

/* rtl/vrs_div.sv */
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor
// uses vrs_pkg
module vrs_div import vrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUO_W-1:0]  dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              busy,
   output logic [QUO_W-1:0]  quotient
);
   localparam int CNT_W = $clog2(QUO_W);

   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DATA_W:0]   rem_sh, diff;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[QUO_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], ge};
         rem_in = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/vrs_sqrt.sv */
// digit-by-digit integer square root, one root bit per cycle, 64-bit radicand
// uses vrs_pkg
module vrs_sqrt import vrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);
   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 3;

   logic [PROD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [REM_W-1:0]  rem_sh, trial;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[PROD_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[PROD_W-3:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

/* rtl/voxel_ray_step_unit.sv */
// voxel ray step unit: a start beat answers in the cycle after acceptance; a step beat runs
// the face search, waiting on the divider per side axis of each face tried, then on the root;
// a move then advances each axis through the multiplier before its result beat.
// one beat at a time: the next beat is taken once the result beat has left.
// synchronous active-high reset clears position, cell, total and sets dir to +x.
// uses vrs_pkg, vrs_mul, vrs_div, vrs_sqrt and the assertion macro header
`include "voxel_ray_step_unit_defines.svh"
module voxel_ray_step_unit import vrs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int CELL_BITS = CELL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // occ_x, occ_y, occ_z, zero pad
   input  logic                  req_tuser,   // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [183:0]          rsp_tdata,   // exit_axis, at_cell_x/y/z, at_pos_x/y/z,
                                              // travel_total, zero pad
   output logic [1:0]            rsp_tuser,   // status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);
   localparam logic signed [34:0] HALF_T = 35'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] HALF_W = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0]  CLIP   = 32'h8000_0000;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_LOC     = 14'b00000000000010,
      S_FACE    = 14'b00000000000100,
      S_TSQ     = 14'b00000000001000,
      S_TSQ_W   = 14'b00000000010000,
      S_OMUL    = 14'b00000000100000,
      S_OMUL_W  = 14'b00000001000000,
      S_DIVW    = 14'b00000010000000,
      S_CHK     = 14'b00000100000000,
      S_OSQ_W   = 14'b00001000000000,
      S_SQRT_GO = 14'b00010000000000,
      S_SQRTW   = 14'b00100000000000,
      S_ADV     = 14'b01000000000000,
      S_ADV_W   = 14'b10000000000000
   } state_type;

   function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // configuration
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] org_ff [3];
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff[0] <= 32'sh0001_0000;
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_DIR_X: dir_ff[0] <= csr_pwdata;
            REG_DIR_Y: dir_ff[1] <= csr_pwdata;
            REG_DIR_Z: dir_ff[2] <= csr_pwdata;
            REG_ORG_X: org_ff[0] <= csr_pwdata;
            REG_ORG_Y: org_ff[1] <= csr_pwdata;
            REG_ORG_Z: org_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DIR_X: csr_prdata = dir_ff[0];
         REG_DIR_Y: csr_prdata = dir_ff[1];
         REG_DIR_Z: csr_prdata = dir_ff[2];
         REG_ORG_X: csr_prdata = org_ff[0];
         REG_ORG_Y: csr_prdata = org_ff[1];
         REG_ORG_Z: csr_prdata = org_ff[2];
         default:   csr_prdata = '0;
      endcase
   end

   // ray state and working registers
   state_type                 state_ff, state_in;
   logic signed [31:0]        pos_ff [3], pos_in [3];
   logic signed [CELL_BITS-1:0] cell_ff [3], cell_in [3];
   logic [DATA_W-1:0]         trav_ff, trav_in;
   logic signed [32:0]        loc_ff [3], loc_in [3];
   logic [DATA_W-1:0]         ad_ff [3], ad_in [3];
   logic [2:0]                neg_ff, neg_in;
   logic [2:0]                occ_ff, occ_in;
   logic [DATA_W-1:0]         tmag_ff, tmag_in;
   logic                      tneg_ff, tneg_in;
   logic [1:0]                face_ff, face_in;
   logic [1:0]                k_ff, k_in;
   logic [PROD_W-1:0]         sum_ff, sum_in;
   logic [ROOT_W-1:0]         len_ff, len_in;
   status_type                status_ff, status_in;
   logic [1:0]                axis_ff, axis_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // shared units
   logic [DATA_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic              div_busy, sqrt_busy;
   logic [QUO_W-1:0]  quo;
   logic [ROOT_W-1:0] root;

   vrs_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   vrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_OMUL_W),
      .dividend (prod),
      .divisor  (ad_ff[face_ff]),
      .busy     (div_busy),
      .quotient (quo)
   );

   vrs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SQRT_GO),
      .radicand (sum_ff),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // combinational helpers
   logic signed [CELL_BITS-1:0] round_w [3];
   logic signed [32:0]          loc_w [3];
   logic [DATA_W-1:0]           ad_w [3];
   logic signed [63:0]          cell_fx;
   logic signed [63:0]          diff_w;
   logic signed [31:0]          l32;
   logic signed [32:0]          half_sum;
   logic signed [32:0]          round_c;
   logic signed [34:0]          t_w;
   logic [DATA_W-1:0]           tclip, qclip;
   logic signed [65:0]          off_w, p_w, np_w;
   logic                        p_inside;
   logic [1:0]                  k_next;
   logic [PROD_W-1:0]           adv_q;
   logic [DATA_W:0]             tot_w;

   always_comb begin
      cell_fx  = '0;
      diff_w   = '0;
      l32      = '0;
      half_sum = '0;
      round_c  = '0;
      for (int i = 0; i < 3; i++) begin
         half_sum    = 33'(org_ff[i]) + 33'(HALF_T);
         round_c     = half_sum >>> FRAC_BITS;
         round_w[i]  = round_c[CELL_BITS-1:0];
         cell_fx     = 64'(cell_ff[i]) <<< FRAC_BITS;
         diff_w      = 64'(pos_ff[i]) - cell_fx;
         l32         = clamp32(66'(diff_w));
         loc_w[i]    = dir_ff[i][31] ? -33'(l32) : 33'(l32);
         ad_w[i]     = dir_ff[i][31] ? 32'(-dir_ff[i]) : 32'(dir_ff[i]);
      end
   end

   always_comb begin
      t_w      = HALF_T - 35'(loc_ff[face_ff]);
      tclip    = (tmag_ff > CLIP) ? CLIP : tmag_ff;
      qclip    = (quo > 64'(CLIP)) ? CLIP : quo[DATA_W-1:0];
      off_w    = tneg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      p_w      = 66'(loc_ff[k_ff]) + off_w;
      p_inside = (p_w >= -HALF_W) && (p_w <= HALF_W);
      // side axes of the face, in ascending order
      k_next   = k_ff + 2'd1;
      if (k_next == face_ff) begin
         k_next = k_next + 2'd1;
      end
      adv_q    = prod >> FRAC_BITS;
      np_w     = neg_ff[k_ff] ? 66'(pos_ff[k_ff]) - $signed({2'b00, adv_q})
                              : 66'(pos_ff[k_ff]) + $signed({2'b00, adv_q});
      tot_w    = {1'b0, trav_ff} + {1'b0, len_ff};
   end

   always_comb begin
      unique case (state_ff)
         S_TSQ: begin
            mul_a = tclip;
            mul_b = tclip;
         end
         S_OMUL: begin
            mul_a = tmag_ff;
            mul_b = ad_ff[k_ff];
         end
         S_CHK: begin
            mul_a = qclip;
            mul_b = qclip;
         end
         S_ADV: begin
            mul_a = len_ff;
            mul_b = ad_ff[k_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cell_in      = cell_ff;
      trav_in      = trav_ff;
      loc_in       = loc_ff;
      ad_in        = ad_ff;
      neg_in       = neg_ff;
      occ_in       = occ_ff;
      tmag_in      = tmag_ff;
      tneg_in      = tneg_ff;
      face_in      = face_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      status_in    = status_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               occ_in = req_tdata[2:0];
               if (req_tuser == CMD_START) begin
                  pos_in       = org_ff;
                  cell_in      = round_w;
                  trav_in      = '0;
                  status_in    = ST_STARTED;
                  axis_in      = AXIS_X;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_LOC;
               end
            end
         end
         S_LOC: begin
            loc_in   = loc_w;
            ad_in    = ad_w;
            neg_in   = {dir_ff[2][31], dir_ff[1][31], dir_ff[0][31]};
            face_in  = AXIS_X;
            state_in = S_FACE;
         end
         S_FACE: begin
            if (face_ff == AXIS_NONE) begin
               status_in    = ST_NO_EXIT;
               axis_in      = AXIS_X;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (ad_ff[face_ff] == '0) begin
               face_in = face_ff + 2'd1;
            end else begin
               tneg_in  = t_w[34];
               tmag_in  = t_w[34] ? 32'(-t_w) : 32'(t_w);
               state_in = S_TSQ;
            end
         end
         S_TSQ: begin
            state_in = S_TSQ_W;
         end
         S_TSQ_W: begin
            sum_in   = prod;
            k_in     = (face_ff == AXIS_X) ? AXIS_Y : AXIS_X;
            state_in = S_OMUL;
         end
         S_OMUL: begin
            state_in = S_OMUL_W;
         end
         S_OMUL_W: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (!div_busy) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (p_inside) begin
               state_in = S_OSQ_W;
            end else begin
               face_in  = face_ff + 2'd1;
               state_in = S_FACE;
            end
         end
         S_OSQ_W: begin
            sum_in = sum_ff + prod;
            if (k_next == AXIS_NONE) begin
               state_in = S_SQRT_GO;
            end else begin
               k_in     = k_next;
               state_in = S_OMUL;
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRTW;
         end
         S_SQRTW: begin
            if (!sqrt_busy) begin
               len_in  = root;
               axis_in = face_ff;
               if (occ_ff[face_ff]) begin
                  status_in    = ST_HIT;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  k_in     = AXIS_X;
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            state_in = S_ADV_W;
         end
         S_ADV_W: begin
            pos_in[k_ff] = clamp32(np_w);
            if (k_ff == AXIS_Z) begin
               cell_in[face_ff] = neg_ff[face_ff] ? cell_ff[face_ff] - 1'b1
                                                  : cell_ff[face_ff] + 1'b1;
               trav_in          = tot_w[DATA_W] ? '1 : tot_w[DATA_W-1:0];
               status_in        = ST_MOVED;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_ADV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '{default: '0};
         cell_ff      <= '{default: '0};
         trav_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         cell_ff      <= cell_in;
         trav_ff      <= trav_in;
      end
      loc_ff    <= loc_in;
      ad_ff     <= ad_in;
      neg_ff    <= neg_in;
      occ_ff    <= occ_in;
      tmag_ff   <= tmag_in;
      tneg_ff   <= tneg_in;
      face_ff   <= face_in;
      k_ff      <= k_in;
      sum_ff    <= sum_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      axis_ff   <= axis_in;
   end

   // result beat straight from the state registers, held until taken
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'b0, trav_ff, pos_ff[2], pos_ff[1], pos_ff[0],
                        CELL_OUT_W'(32'(cell_ff[2])),
                        CELL_OUT_W'(32'(cell_ff[1])),
                        CELL_OUT_W'(32'(cell_ff[0])),
                        axis_ff};

   `VRS_ASSERT_IMPL(a_no_take_while_pending, clock, reset, rsp_tvalid, !req_tready)
   `VRS_ASSERT_NEXT(a_start_answers_next, clock, reset, req_tvalid && req_tready && req_tuser == CMD_START, rsp_tvalid && rsp_tuser == ST_STARTED)
   `VRS_ASSERT_IMPL(a_div_only_in_wait, clock, reset, div_busy, state_ff == S_DIVW)
   `VRS_ASSERT_IMPL(a_no_exit_axis_zero, clock, reset, rsp_tvalid && rsp_tuser == ST_NO_EXIT, rsp_tdata[1:0] == AXIS_X)
endmodule

/* dv/tb.sv */
// self-checking testbench for voxel_ray_step_unit: random and directed start/step beats,
// per-beat prediction of cell, position, total and status, apb register setup between runs
// depends on vrs_pkg and the rtl of voxel_ray_step_unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vrs_pkg::*;

   localparam int  FRAC      = FRAC_BITS_DEF;
   localparam longint HALF   = longint'(1) << (FRAC - 1);
   localparam longint ONE    = longint'(1) << FRAC;
   localparam int  STALL_MAX = 20000;
   localparam int  HOLD_LEN  = 2000;
   localparam int  NUM_RUNS  = 24;
   localparam int  RUN_BEATS = 72;

   typedef struct packed {
      status_type  st;
      logic [1:0]  axis;
      logic [15:0] cx, cy, cz;
      logic [31:0] px, py, pz;
      logic [31:0] tot;
   } ray_result_type;

   typedef struct packed {
      logic       cmd;
      logic [2:0] occ;
   } ray_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, rsp_tready = 1'b0;
   logic req_tready, rsp_tvalid;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic [183:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   voxel_ray_step_unit i_dut (.*);

   always #4 clock = ~clock;

   // predictor copy of registers and ray state
   logic [31:0] dir_reg [3];
   logic [31:0] org_reg [3];
   logic [31:0] ray_pos [3];
   logic [15:0] ray_cell [3];
   logic [31:0] ray_total;

   ray_beat_type   pending_beats [$];
   ray_result_type expected_results [$];
   int error_count = 0;
   int idle_mode = 0;
   bit hold_request = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit [63:0] clip_mag(longint v);
      bit [63:0] u;
      u = (v < 0) ? 64'(-v) : 64'(v);
      return (u > 64'h8000_0000) ? 64'h8000_0000 : u;
   endfunction

   function automatic bit [63:0] floor_sqrt(bit [63:0] n);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // exit face test on the mirrored local frame; returns 1 and the step length on success
   function automatic bit face_exit(int a, longint loc[3], longint ad[3],
                                    output bit [63:0] len);
      longint t, off, p;
      bit [63:0] m, sum;
      t = HALF - loc[a];
      m = clip_mag(t);
      sum = m * m;
      len = 0;
      for (int k = 0; k < 3; k++) begin
         if (k == a) continue;
         off = (t * ad[k]) / ad[a];
         p = loc[k] + off;
         if (p < -HALF || p > HALF) return 0;
         m = clip_mag(off);
         sum += m * m;
      end
      len = floor_sqrt(sum);
      return 1;
   endfunction

   function automatic ray_result_type trace_beat(ray_beat_type b);
      ray_result_type r;
      longint loc[3], ad[3], d, q;
      bit [63:0] len, md, tsum;
      int found;
      r.st = ST_NO_EXIT;
      r.axis = AXIS_X;
      if (b.cmd == CMD_START) begin
         for (int k = 0; k < 3; k++) begin
            ray_pos[k] = org_reg[k];
            ray_cell[k] = 16'((longint'($signed(org_reg[k])) + HALF) >>> FRAC);
         end
         ray_total = 0;
         r.st = ST_STARTED;
      end else begin
         for (int k = 0; k < 3; k++) begin
            d = longint'($signed(dir_reg[k]));
            loc[k] = clamp32(longint'($signed(ray_pos[k]))
                             - longint'($signed(ray_cell[k])) * ONE);
            if (d < 0) begin
               d = -d;
               loc[k] = -loc[k];
            end
            ad[k] = d;
         end
         found = -1;
         for (int a = 0; a < 3 && found < 0; a++)
            if (ad[a] != 0 && face_exit(a, loc, ad, len)) found = a;
         if (found >= 0) begin
            r.axis = 2'(found);
            if (b.occ[found]) begin
               r.st = ST_HIT;
            end else begin
               r.st = ST_MOVED;
               for (int k = 0; k < 3; k++) begin
                  d = longint'($signed(dir_reg[k]));
                  md = (d < 0) ? 64'(-d) : 64'(d);
                  q = longint'((len * md) >> FRAC);
                  ray_pos[k] = 32'(clamp32(longint'($signed(ray_pos[k]))
                                           + ((d < 0) ? -q : q)));
               end
               if ($signed(dir_reg[found]) < 0) ray_cell[found] = ray_cell[found] - 16'd1;
               else ray_cell[found] = ray_cell[found] + 16'd1;
               tsum = 64'(ray_total) + len;
               ray_total = (tsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(tsum);
            end
         end
      end
      r.cx = ray_cell[0]; r.cy = ray_cell[1]; r.cz = ray_cell[2];
      r.px = ray_pos[0];  r.py = ray_pos[1];  r.pz = ray_pos[2];
      r.tot = ray_total;
      return r;
   endfunction

   function automatic bit roll(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // driver: predicts on acceptance, then offers the next beat or idles
   always @(posedge clock) begin
      ray_beat_type nb;
      bit offer;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_results.push_back(trace_beat('{cmd: req_tuser, occ: req_tdata[2:0]}));
         if (!req_tvalid || req_tready) begin
            offer = pending_beats.size() > 0
                    && !(idle_mode == 0 && roll(30)) && !(idle_mode == 1 && roll(55));
            if (offer) begin
               nb = pending_beats.pop_front();
               req_tuser <= nb.cmd;
               req_tdata <= {5'd0, nb.occ};
            end
            req_tvalid <= offer;
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // receiver ready and result checker
   int hold_left = 0;
   bit hold_started = 0;
   always @(posedge clock) begin
      ray_result_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", {30'd0, rsp_tuser}, 32'd0);
            end else begin
               e = expected_results.pop_front();
               if (rsp_tuser != e.st) report_mismatch("status", rsp_tuser, e.st);
               if (rsp_tdata[1:0] != e.axis) report_mismatch("exit_axis", rsp_tdata[1:0], e.axis);
               if (rsp_tdata[17:2] != e.cx) report_mismatch("cell_x", rsp_tdata[17:2], e.cx);
               if (rsp_tdata[33:18] != e.cy) report_mismatch("cell_y", rsp_tdata[33:18], e.cy);
               if (rsp_tdata[49:34] != e.cz) report_mismatch("cell_z", rsp_tdata[49:34], e.cz);
               if (rsp_tdata[81:50] != e.px) report_mismatch("pos_x", rsp_tdata[81:50], e.px);
               if (rsp_tdata[113:82] != e.py) report_mismatch("pos_y", rsp_tdata[113:82], e.py);
               if (rsp_tdata[145:114] != e.pz) report_mismatch("pos_z", rsp_tdata[145:114], e.pz);
               if (rsp_tdata[177:146] != e.tot)
                  report_mismatch("travel_total", rsp_tdata[177:146], e.tot);
               if (rsp_tdata[183:178] != 0) report_mismatch("pad", rsp_tdata[183:178], 0);
            end
         end
         if (hold_request && !hold_started) begin
            hold_started <= 1;
            hold_left <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !((idle_mode == 0 && roll(55)) || (idle_mode == 1 && roll(30)));
         end
      end
   end

   // watchdog on cycles with no beat moving
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx <= REG_DIR_Z) dir_reg[idx] = val;
      else org_reg[idx - REG_ORG_X] = val;
   endtask

   task automatic set_ray(logic [31:0] dx, dy, dz, ox, oy, oz);
      csr_write(REG_DIR_X, dx);
      csr_write(REG_DIR_Y, dy);
      csr_write(REG_DIR_Z, dz);
      csr_write(REG_ORG_X, ox);
      csr_write(REG_ORG_Y, oy);
      csr_write(REG_ORG_Z, oz);
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic push(logic cmd, logic [2:0] occ);
      pending_beats.push_back('{cmd: cmd, occ: occ});
   endtask

   function automatic logic [31:0] rand_dir();
      case ($urandom_range(9, 0))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3, 4: return $urandom();
         default: return 32'($signed($urandom_range(1 << 18, 0)) - (1 << 17));
      endcase
   endfunction

   function automatic logic [31:0] rand_origin();
      case ($urandom_range(7, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom();
         default: return 32'($signed($urandom_range(1 << 22, 0)) - (1 << 21));
      endcase
   endfunction

   function automatic logic [2:0] rand_occ();
      return {roll(15), roll(15), roll(15)};
   endfunction

   initial begin
      dir_reg = '{32'h0001_0000, 32'd0, 32'd0};
      org_reg = '{32'd0, 32'd0, 32'd0};
      ray_pos = '{32'd0, 32'd0, 32'd0};
      ray_cell = '{16'd0, 16'd0, 16'd0};
      ray_total = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_mode = 2;

      // reset direction +x: start, moves, hit across x, a bare step after reset first
      push(CMD_STEP, 3'b000);
      push(CMD_START, 3'b111);
      push(CMD_STEP, 3'b000);
      push(CMD_STEP, 3'b110);
      push(CMD_STEP, 3'b001);
      drain();
      // zero direction gives no exit face
      set_ray(32'd0, 32'd0, 32'd0, 32'h0000_8000, 32'hFFFF_8000, 32'd0);
      push(CMD_START, 3'b000);
      push(CMD_STEP, 3'b111);
      drain();
      // negative diagonal through corners
      set_ray(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0);
      push(CMD_START, 3'b000);
      push(CMD_STEP, 3'b000);
      push(CMD_STEP, 3'b001);
      push(CMD_STEP, 3'b000);
      drain();
      set_ray(32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0);
      push(CMD_START, 3'b000);
      push(CMD_STEP, 3'b100);
      push(CMD_STEP, 3'b011);
      drain();
      // extreme origin: cell wraps, local offset saturates, total saturates
      set_ray(32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF);
      push(CMD_START, 3'b000);
      repeat (4) push(CMD_STEP, 3'b000);
      drain();
      set_ray(32'h0001_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
      push(CMD_START, 3'b000);
      repeat (3) push(CMD_STEP, 3'b000);
      drain();

      for (int run = 0; run < NUM_RUNS; run++) begin
         idle_mode = (run < 8) ? 0 : (run < 16) ? 1 : 2;
         set_ray(rand_dir(), rand_dir(), rand_dir(),
                 rand_origin(), rand_origin(), rand_origin());
         push(CMD_START, rand_occ());
         for (int n = 1; n < RUN_BEATS; n++)
            push(roll(5) ? CMD_START : CMD_STEP, rand_occ());
         if (run == 10) hold_request = 1;
         drain();
      end

      repeat (600) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
